/* rtl/mpc_pkg.sv */
// ============================================================================
// Mandelbrot pixel color package
// Shared defaults, controller/datapath interface types and the color palette.
// ============================================================================
package mpc_pkg;

    // Default configuration handed to the top level parameters.
    localparam int DEF_IMAGE_WIDTH    = 3840;
    localparam int DEF_IMAGE_HEIGHT   = 2160;
    localparam int DEF_MAX_ITERATIONS = 2000;
    localparam int DEF_FRACTION_BITS  = 28;

    // Fixed field widths.
    localparam int COORD_W = 12;
    localparam int ESC_W   = 11;
    localparam int CHAN_W  = 8;
    // Widest iteration count the parameter range allows.
    localparam int COUNT_W = 16;
    // Integer bits of every fixed-point word, sign included.
    localparam int INT_BITS = 8;

    // Coordinate scaling: re = col*7/(2*width) - 5/2, im = row*2/height - 1.
    localparam int RE_SCALE   = 7;
    localparam int IM_SCALE   = 2;
    localparam int RE_OFF_NUM = 5;
    localparam int ESC_LIMIT  = 4;

    // Palette levels.
    localparam logic [CHAN_W-1:0] LVL_ZERO = 8'h00;
    localparam logic [CHAN_W-1:0] LVL_LO   = 8'h55;
    localparam logic [CHAN_W-1:0] LVL_HI   = 8'hAA;
    localparam logic [CHAN_W-1:0] LVL_FULL = 8'hFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COORD,
        S_CSET,
        S_ABS,
        S_MUL,
        S_SUM,
        S_NORM,
        S_TEST
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic c_set;
        logic abs_op;
        logic mul;
        logic sum;
        logic norm;
        logic advance;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic escape;
        logic last_iter;
    } t_status;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    // Sixteen-entry CGA palette; the default arm holds bright white.
    function automatic t_rgb cga_color(logic [3:0] idx);
        t_rgb c;
        case (idx)
            4'd0:    c = '{LVL_ZERO, LVL_ZERO, LVL_ZERO};
            4'd1:    c = '{LVL_ZERO, LVL_ZERO, LVL_HI};
            4'd2:    c = '{LVL_ZERO, LVL_HI,   LVL_ZERO};
            4'd3:    c = '{LVL_ZERO, LVL_HI,   LVL_HI};
            4'd4:    c = '{LVL_HI,   LVL_ZERO, LVL_ZERO};
            4'd5:    c = '{LVL_HI,   LVL_ZERO, LVL_HI};
            4'd6:    c = '{LVL_HI,   LVL_LO,   LVL_ZERO};
            4'd7:    c = '{LVL_HI,   LVL_HI,   LVL_HI};
            4'd8:    c = '{LVL_LO,   LVL_LO,   LVL_LO};
            4'd9:    c = '{LVL_LO,   LVL_LO,   LVL_FULL};
            4'd10:   c = '{LVL_LO,   LVL_FULL, LVL_LO};
            4'd11:   c = '{LVL_LO,   LVL_FULL, LVL_FULL};
            4'd12:   c = '{LVL_FULL, LVL_LO,   LVL_LO};
            4'd13:   c = '{LVL_FULL, LVL_LO,   LVL_FULL};
            4'd14:   c = '{LVL_FULL, LVL_FULL, LVL_LO};
            default: c = '{LVL_FULL, LVL_FULL, LVL_FULL};
        endcase
        return c;
    endfunction

    // Full palette: CGA below sixteen, a fading ramp per channel above.
    function automatic t_rgb palette(logic [COUNT_W-1:0] cnt);
        t_rgb              c;
        logic [CHAN_W-1:0] lvl;
        lvl = LVL_FULL - {1'b0, cnt[3:0], 3'b000};
        if (cnt < COUNT_W'(16)) begin
            c = cga_color(cnt[3:0]);
        end else begin
            c.red   = cnt[4] ? lvl : LVL_ZERO;
            c.green = cnt[5] ? lvl : LVL_ZERO;
            c.blue  = cnt[6] ? lvl : LVL_ZERO;
        end
        return c;
    endfunction

endpackage

/* rtl/mpc_ctrl.sv */
// ============================================================================
// Mandelbrot pixel controller
// Sequences coordinate division, the iteration steps and the result strobe.
// ============================================================================
module mpc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  mpc_pkg::t_status i_status,
    output logic             o_busy,
    output mpc_pkg::t_cmd    o_cmd
);

    mpc_pkg::t_state r_state;
    mpc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            mpc_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = mpc_pkg::S_COORD;
                end
            end
            mpc_pkg::S_COORD: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = mpc_pkg::S_CSET;
                end
            end
            mpc_pkg::S_CSET: begin
                o_cmd.c_set = 1'b1;
                n_state     = mpc_pkg::S_ABS;
            end
            mpc_pkg::S_ABS: begin
                o_cmd.abs_op = 1'b1;
                n_state      = mpc_pkg::S_MUL;
            end
            mpc_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = mpc_pkg::S_SUM;
            end
            mpc_pkg::S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = mpc_pkg::S_NORM;
            end
            mpc_pkg::S_NORM: begin
                o_cmd.norm = 1'b1;
                n_state    = mpc_pkg::S_TEST;
            end
            mpc_pkg::S_TEST: begin
                if (i_status.escape || i_status.last_iter) begin
                    o_cmd.finish = 1'b1;
                    n_state      = mpc_pkg::S_IDLE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = mpc_pkg::S_ABS;
                end
            end
            default: begin
                n_state = mpc_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != mpc_pkg::S_IDLE);

endmodule

/* rtl/mpc_datapath.sv */
// ============================================================================
// Mandelbrot pixel datapath
// Coordinate scaling by constant reciprocals, split multipliers, iteration
// update and the registered result with its palette color.
// ============================================================================
module mpc_datapath #(
    parameter int IMAGE_WIDTH    = mpc_pkg::DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT   = mpc_pkg::DEF_IMAGE_HEIGHT,
    parameter int MAX_ITERATIONS = mpc_pkg::DEF_MAX_ITERATIONS,
    parameter int FRACTION_BITS  = mpc_pkg::DEF_FRACTION_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mpc_pkg::t_cmd                i_cmd,
    input  logic [mpc_pkg::COORD_W-1:0]  i_pixel_column,
    input  logic [mpc_pkg::COORD_W-1:0]  i_pixel_row,
    output mpc_pkg::t_status             o_status,
    output logic                         o_valid,
    output logic [mpc_pkg::ESC_W-1:0]    o_escape_count,
    output logic [mpc_pkg::CHAN_W-1:0]   o_red,
    output logic [mpc_pkg::CHAN_W-1:0]   o_green,
    output logic [mpc_pkg::CHAN_W-1:0]   o_blue
);

    localparam int W      = FRACTION_BITS + mpc_pkg::INT_BITS;
    localparam int PW     = W + FRACTION_BITS;
    localparam int CW     = $clog2(MAX_ITERATIONS + 1);
    localparam int NUM_W  = mpc_pkg::COORD_W + 3;
    localparam int DEN_RE = 2 * IMAGE_WIDTH;
    localparam int DEN_IM = IMAGE_HEIGHT;
    localparam int HALF   = 32;
    localparam int MAGW   = 2 * HALF;
    localparam int SUMW   = 2 * MAGW;

    // Coordinate scaling runs in a fixed number of steps.
    localparam int COORD_STEPS = 2;
    localparam int DCW         = 2;
    localparam int PL_W        = NUM_W + HALF;

    // floor(a*2^F/den) = a*QI + floor(a*RI/den), with QI and RI the quotient
    // and remainder of 2^F/den. The last term is a small exact division,
    // done as a multiplication by a rounded-up reciprocal M and a shift.
    localparam logic [63:0] ONE_FX = 64'd1 << FRACTION_BITS;
    localparam logic [63:0] QI_RE  = ONE_FX / 64'(DEN_RE);
    localparam logic [63:0] RI_RE  = ONE_FX % 64'(DEN_RE);
    localparam logic [63:0] QI_IM  = ONE_FX / 64'(DEN_IM);
    localparam logic [63:0] RI_IM  = ONE_FX % 64'(DEN_IM);
    localparam int          LG_RE  = $clog2(DEN_RE);
    localparam int          LG_IM  = $clog2(DEN_IM);
    localparam int          RN_RE  = NUM_W + LG_RE;
    localparam int          RN_IM  = NUM_W + LG_IM;
    localparam int          SH_RE  = RN_RE + LG_RE;
    localparam int          SH_IM  = RN_IM + LG_IM;
    localparam int          MR_RE  = 2 * RN_RE + 1;
    localparam int          MR_IM  = 2 * RN_IM + 1;
    localparam logic [63:0] M_RE   = ((64'd1 << SH_RE) + 64'(DEN_RE) - 64'd1) / 64'(DEN_RE);
    localparam logic [63:0] M_IM   = ((64'd1 << SH_IM) + 64'(DEN_IM) - 64'd1) / 64'(DEN_IM);

    localparam logic [W-1:0] OFF_RE = W'(mpc_pkg::RE_OFF_NUM) << (FRACTION_BITS - 1);
    localparam logic [W-1:0] OFF_IM = W'(1) << FRACTION_BITS;
    localparam logic [W-1:0] LIMIT  = W'(mpc_pkg::ESC_LIMIT) << FRACTION_BITS;

    // Coordinate scaling.
    logic [NUM_W-1:0] r_sc_re, r_sc_im;
    logic [PL_W-1:0]  r_plo_re, r_phi_re, r_plo_im, r_phi_im;
    logic [RN_RE-1:0] r_rp_re;
    logic [RN_IM-1:0] r_rp_im;
    logic [W-1:0]     r_base_re, r_base_im;
    logic [NUM_W-1:0] r_frac_re, r_frac_im;
    logic [DCW-1:0]   r_div_cnt;

    // Iteration state.
    logic [W-1:0]     r_cre, r_cim, r_x, r_y;
    logic [W-1:0]     r_mag_x, r_mag_y;
    logic             r_neg_x, r_neg_y;
    logic [CW-1:0]    r_iter;

    // Products: index 0 is x*x, 1 is y*y, 2 is x*y.
    logic [MAGW-1:0]  r_pp   [3][4];
    logic             r_pneg [3];
    logic [PW-1:0]    r_pmag [3];
    logic [W-1:0]     r_prod [3];
    logic [MAGW-1:0]  w_opa  [3];
    logic [MAGW-1:0]  w_opb  [3];

    logic [W-1:0]     w_mag2, w_xn, w_yn;
    logic [CW-1:0]    w_count;
    mpc_pkg::t_rgb    w_rgb;

    logic                         r_valid;
    logic [mpc_pkg::ESC_W-1:0]    r_escape_count;
    mpc_pkg::t_rgb                r_rgb;

    // The first step forms the constant products of the scaled coordinate,
    // the second sums them and applies the reciprocal to the remainder term.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sc_re   <= NUM_W'(i_pixel_column) * NUM_W'(mpc_pkg::RE_SCALE);
            r_sc_im   <= NUM_W'(i_pixel_row) * NUM_W'(mpc_pkg::IM_SCALE);
            r_div_cnt <= DCW'(COORD_STEPS);
        end else if (i_cmd.div_step) begin
            r_plo_re  <= PL_W'(r_sc_re) * PL_W'(QI_RE[HALF-1:0]);
            r_phi_re  <= PL_W'(r_sc_re) * PL_W'(QI_RE[MAGW-1:HALF]);
            r_rp_re   <= RN_RE'(r_sc_re) * RN_RE'(RI_RE);
            r_plo_im  <= PL_W'(r_sc_im) * PL_W'(QI_IM[HALF-1:0]);
            r_phi_im  <= PL_W'(r_sc_im) * PL_W'(QI_IM[MAGW-1:HALF]);
            r_rp_im   <= RN_IM'(r_sc_im) * RN_IM'(RI_IM);
            r_base_re <= W'(r_plo_re) + W'({r_phi_re, {HALF{1'b0}}});
            r_base_im <= W'(r_plo_im) + W'({r_phi_im, {HALF{1'b0}}});
            r_frac_re <= NUM_W'((MR_RE'(r_rp_re) * MR_RE'(M_RE)) >> SH_RE);
            r_frac_im <= NUM_W'((MR_IM'(r_rp_im) * MR_IM'(M_IM)) >> SH_IM);
            r_div_cnt <= r_div_cnt - DCW'(1);
        end
    end

    // Operand selection for the three products.
    always_comb begin
        w_opa[0] = MAGW'(r_mag_x);
        w_opb[0] = MAGW'(r_mag_x);
        w_opa[1] = MAGW'(r_mag_y);
        w_opb[1] = MAGW'(r_mag_y);
        w_opa[2] = MAGW'(r_mag_x);
        w_opb[2] = MAGW'(r_mag_y);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.abs_op) begin
            r_neg_x <= r_x[W-1];
            r_neg_y <= r_y[W-1];
            r_mag_x <= r_x[W-1] ? W'(W'(0) - r_x) : r_x;
            r_mag_y <= r_y[W-1] ? W'(W'(0) - r_y) : r_y;
        end
        for (int k = 0; k < 3; k++) begin
            if (i_cmd.mul) begin
                r_pp[k][0] <= MAGW'(w_opa[k][HALF-1:0]) * MAGW'(w_opb[k][HALF-1:0]);
                r_pp[k][1] <= MAGW'(w_opa[k][HALF-1:0]) * MAGW'(w_opb[k][MAGW-1:HALF]);
                r_pp[k][2] <= MAGW'(w_opa[k][MAGW-1:HALF]) * MAGW'(w_opb[k][HALF-1:0]);
                r_pp[k][3] <= MAGW'(w_opa[k][MAGW-1:HALF]) * MAGW'(w_opb[k][MAGW-1:HALF]);
                r_pneg[k]  <= (k == 2) ? (r_neg_x ^ r_neg_y) : 1'b0;
            end
            if (i_cmd.sum) begin
                r_pmag[k] <= PW'(SUMW'(r_pp[k][0])
                               + (SUMW'(r_pp[k][1]) << HALF)
                               + (SUMW'(r_pp[k][2]) << HALF)
                               + (SUMW'(r_pp[k][3]) << MAGW));
            end
            if (i_cmd.norm) begin
                // Negating before the shift makes the drop of fraction bits a floor.
                r_prod[k] <= r_pneg[k] ? W'((PW'(0) - r_pmag[k]) >> FRACTION_BITS)
                                       : W'(r_pmag[k] >> FRACTION_BITS);
            end
        end
    end

    // Escape test and next z.
    assign w_mag2  = r_prod[0] + r_prod[1];
    assign w_xn    = r_prod[0] - r_prod[1] + r_cre;
    assign w_yn    = {r_prod[2][W-2:0], 1'b0} + r_cim;
    assign w_count = o_status.escape ? r_iter : '0;
    assign w_rgb   = mpc_pkg::palette(mpc_pkg::COUNT_W'(w_count));

    assign o_status.div_last  = (r_div_cnt == DCW'(1));
    assign o_status.escape    = ($signed(w_mag2) > $signed(LIMIT));
    assign o_status.last_iter = (r_iter == CW'(MAX_ITERATIONS - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= '0;
            r_y    <= '0;
            r_iter <= '0;
        end else if (i_cmd.advance) begin
            r_x    <= w_xn;
            r_y    <= w_yn;
            r_iter <= r_iter + CW'(1);
        end
        if (i_cmd.c_set) begin
            r_cre <= r_base_re + W'(r_frac_re) - OFF_RE;
            r_cim <= r_base_im + W'(r_frac_im) - OFF_IM;
        end
        if (i_cmd.finish) begin
            r_escape_count <= mpc_pkg::ESC_W'(w_count);
            r_rgb          <= w_rgb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
        end
    end

    assign o_valid        = r_valid;
    assign o_escape_count = r_escape_count;
    assign o_red          = r_rgb.red;
    assign o_green        = r_rgb.green;
    assign o_blue         = r_rgb.blue;

endmodule

/* rtl/mandelbrot_pixel_color.sv */
// ============================================================================
// Mandelbrot pixel color
// Escape-time count and palette color for one pixel, in signed Q8.F fixed
// point, computed by a controller and a shared iteration datapath.
// ============================================================================
//
// Channel   Direction  Handshake            Payload
// -------   ---------  -------------------  ---------------------------------
// command   in         start high, busy low i_pixel_column, i_pixel_row
// result    out        o_valid, one cycle   o_escape_count, o_red/green/blue
//
// Sequence: after the accepting edge a pixel scales its coordinates with
// constant reciprocal products, forms c, then runs escape tests, each one
// as magnitude, partial products, product sum, flooring, test and update.
// A pixel that escapes after n iterations runs n + 1 tests and one that
// never escapes runs MAX_ITERATIONS of them, so the iteration loop through
// the split multipliers sets the time a pixel takes.
// The result strobe comes in the cycle after the last test, and busy is
// already low in that cycle, so the next transaction may start at once.
// Reset is synchronous and active low; it returns the controller to idle and
// clears the strobe. The receiver cannot stall: each result is shown for
// exactly one cycle.
//
module mandelbrot_pixel_color #(
    parameter int IMAGE_WIDTH    = mpc_pkg::DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT   = mpc_pkg::DEF_IMAGE_HEIGHT,
    parameter int MAX_ITERATIONS = mpc_pkg::DEF_MAX_ITERATIONS,
    parameter int FRACTION_BITS  = mpc_pkg::DEF_FRACTION_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [mpc_pkg::COORD_W-1:0]  i_pixel_column,
    input  logic [mpc_pkg::COORD_W-1:0]  i_pixel_row,
    output logic                         o_valid,
    output logic [mpc_pkg::ESC_W-1:0]    o_escape_count,
    output logic [mpc_pkg::CHAN_W-1:0]   o_red,
    output logic [mpc_pkg::CHAN_W-1:0]   o_green,
    output logic [mpc_pkg::CHAN_W-1:0]   o_blue
);

    // Commands from the controller and status back from the datapath.
    mpc_pkg::t_cmd    w_cmd;
    mpc_pkg::t_status w_status;

    // The controller accepts a transaction only from idle; the coordinates
    // are captured into the scaling registers on the same edge, so the input
    // ports need not hold afterwards.
    mpc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_busy   (busy),
        .o_cmd    (w_cmd)
    );

    // The datapath holds z, c, the iteration count and the result register.
    // The three products of one iteration run in parallel, each split into
    // four 32 by 32 partial products.
    mpc_datapath #(
        .IMAGE_WIDTH    (IMAGE_WIDTH),
        .IMAGE_HEIGHT   (IMAGE_HEIGHT),
        .MAX_ITERATIONS (MAX_ITERATIONS),
        .FRACTION_BITS  (FRACTION_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_pixel_column (i_pixel_column),
        .i_pixel_row    (i_pixel_row),
        .o_status       (w_status),
        .o_valid        (o_valid),
        .o_escape_count (o_escape_count),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue)
    );

endmodule

/* rtl/mpc_checker.sv */
// ============================================================================
// Mandelbrot pixel color checker
// Port-level assertions on the result strobe, busy and palette colors.
// ============================================================================
module mpc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_start,
    input logic                        i_busy,
    input logic                        i_valid,
    input logic [mpc_pkg::ESC_W-1:0]   i_escape_count,
    input logic [mpc_pkg::CHAN_W-1:0]  i_red,
    input logic [mpc_pkg::CHAN_W-1:0]  i_green,
    input logic [mpc_pkg::CHAN_W-1:0]  i_blue
);

    // Reset leaves the block idle with no result pending.
    assert property (@(posedge i_clk) !i_rst_n |=> (!i_valid && !i_busy))
        else $error("block not idle after reset");

    // A result appears only after the transaction has left the busy phase.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_valid |-> !i_busy)
        else $error("result strobe while busy");

    // An accepted transaction turns busy on without an immediate result strobe.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy) |=> (i_busy && !i_valid))
        else $error("transaction finished too early");

    // A zero count is a point inside the set and is drawn black.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_escape_count == '0) |->
        (i_red == '0 && i_green == '0 && i_blue == '0))
        else $error("nonblack color for zero count");

    // Ramp colors have all nonzero channels at the same level.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_escape_count >= mpc_pkg::ESC_W'(16) && i_red != '0 && i_green != '0)
        |-> (i_red == i_green))
        else $error("ramp channels differ");

endmodule

bind mandelbrot_pixel_color mpc_checker u_mpc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (start),
    .i_busy         (busy),
    .i_valid        (o_valid),
    .i_escape_count (o_escape_count),
    .i_red          (o_red),
    .i_green        (o_green),
    .i_blue         (o_blue)
);
